// File: design/mlcd_pkg.sv
// Shared constants, types and the CRC byte update for the frame deframer.
`timescale 1ns / 1ps
package mlcd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int FIELD_BYTES  = 8;
    localparam int WORD_BITS    = 32;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] PASS_MARK  = 16'hCCCC;
    localparam logic [15:0] MIN_LEN_LO = 16'd2;

    localparam logic [1:0] ST_GOOD      = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BAD_CRC   = 2'd3;

    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    typedef struct packed {
        logic [31:0] header_magic;
        logic [15:0] min_body_len;
        logic [15:0] max_body_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic        frame_end;
        logic [1:0]  status;
        logic [15:0] body_length;
    } result_t;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: design/magic_length_crc_frame_deframer.sv
// Top level: config registers, input register, frame core and result register.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte                     | in
//  output  | out_valid, out_stall, body_byte, frame_end,     | out
//          | status, body_length                             |
//  config  | cfg_we, cfg_index, cfg_data                     | in
//
// One byte per cycle while the result register is not held by out_stall; a result
// passes the input register, then the result register, and is taken when out_stall
// is low; header bytes give none but the last, and that only on a bad magic or length.
// The whole per-byte step (CRC update, header checks) sits between those two.
// Reset returns to header collection with config at magic 0, limits 2..65535.
// in_stall rises only when the input register is full and the result register
// is held by out_stall.
`timescale 1ns / 1ps
module magic_length_crc_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  body_byte,
    output logic        frame_end,
    output logic [1:0]  status,
    output logic [15:0] body_length,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mlcd_pkg::*;

    cfg_t    cfg_reg;
    logic    s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_load;
    logic    s1_fire;
    logic    res_valid;
    result_t res;

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_magic <= '0;
            cfg_reg.min_body_len <= MIN_LEN_LO;
            cfg_reg.max_body_len <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAGIC:   cfg_reg.header_magic <= cfg_data;
                CFG_MIN_LEN: cfg_reg.min_body_len <= cfg_data[15:0];
                CFG_MAX_LEN: cfg_reg.max_body_len <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            s1_byte_reg <= rx_byte;
    end

    mlcd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .rx_byte   (s1_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s1_valid_reg && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
            out_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign body_byte   = out_reg.body_byte;
    assign frame_end   = out_reg.frame_end;
    assign status      = out_reg.status;
    assign body_length = out_reg.body_length;

`ifndef SYNTHESIS
    a_status_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.frame_end |-> out_reg.status == ST_GOOD)
        else $error("nonzero status on a mid-frame byte");

    a_hdr_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_BAD_MAGIC || out_reg.status == ST_BAD_LEN)
        |-> out_reg.frame_end && out_reg.body_byte == 8'h00 && out_reg.body_length == 16'h0000)
        else $error("header error result with payload");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

// File: design/mlcd_core.sv
// Frame state: header collection, checks, body CRC and verdict.
`timescale 1ns / 1ps
module mlcd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       rx_byte,
    input  mlcd_pkg::cfg_t   cfg,
    output logic             res_valid,
    output mlcd_pkg::result_t res
);
    import mlcd_pkg::*;

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_BODY   = 1'b1;

    logic        phase_reg, phase_next;
    logic [63:0] shift_reg, shift_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] last_reg, last_next;

    logic [15:0] count_inc;
    logic [15:0] crc_upd;
    logic [15:0] last_upd;
    logic [63:0] shift_upd;
    logic [31:0] magic_w;
    logic [31:0] len_w;
    logic [15:0] lo_len;
    logic        bad_len;

    assign count_inc = count_reg + 16'd1;
    assign crc_upd   = crc_byte(crc_reg, rx_byte);
    assign last_upd  = {last_reg[7:0], rx_byte};
    assign shift_upd = (count_reg < 16'(FIELD_BYTES)) ? {shift_reg[55:0], rx_byte} : shift_reg;
    assign magic_w   = shift_upd[63:WORD_BITS];
    assign len_w     = shift_upd[WORD_BITS-1:0];
    assign lo_len    = (cfg.min_body_len < MIN_LEN_LO) ? MIN_LEN_LO : cfg.min_body_len;
    assign bad_len   = len_w[31] || (len_w < {16'h0000, lo_len})
                       || (len_w > {16'h0000, cfg.max_body_len});

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        flen_next  = flen_reg;
        crc_next   = crc_reg;
        last_next  = last_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (phase_reg == PH_BODY)
        begin
            res_valid       = 1'b1;
            res.body_byte   = rx_byte;
            res.body_length = flen_reg;
            crc_next        = crc_upd;
            last_next       = last_upd;
            count_next      = count_inc;
            if (count_inc >= flen_reg)
            begin
                res.frame_end = 1'b1;
                res.status    = (crc_upd == 16'h0000 || last_upd == PASS_MARK)
                                ? ST_GOOD : ST_BAD_CRC;
                phase_next    = PH_HEADER;
                shift_next    = '0;
                count_next    = '0;
                crc_next      = CRC_INIT;
                last_next     = '0;
            end
        end
        else
        begin
            shift_next = shift_upd;
            count_next = count_inc;
            if (count_inc >= 16'(HEADER_BYTES))
            begin
                shift_next = '0;
                count_next = '0;
                crc_next   = CRC_INIT;
                last_next  = '0;
                if (magic_w != cfg.header_magic)
                begin
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                    res.status    = ST_BAD_MAGIC;
                end
                else if (bad_len)
                begin
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                    res.status    = ST_BAD_LEN;
                end
                else
                begin
                    phase_next = PH_BODY;
                    flen_next  = len_w[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            shift_reg <= '0;
            count_reg <= '0;
            flen_reg  <= '0;
            crc_reg   <= CRC_INIT;
            last_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            flen_reg  <= flen_next;
            crc_reg   <= crc_next;
            last_reg  <= last_next;
        end
    end

`ifndef SYNTHESIS
    a_body_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> flen_reg >= MIN_LEN_LO)
        else $error("body phase with length below two");

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> count_reg < 16'(HEADER_BYTES))
        else $error("header byte count overran");

    a_hdr_crc: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> crc_reg == CRC_INIT && last_reg == 16'h0000)
        else $error("CRC state not reset during header");
`endif

endmodule

// File: tb/magic_length_crc_frame_deframer_test.sv
// Self-checking bench for the deframer: framed byte traffic, a frame predictor and a scoreboard.
`timescale 1ns / 1ps
module magic_length_crc_frame_deframer_test;
    import mlcd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 270;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int TAIL_CRC    = 0;
    localparam int TAIL_MARK   = 1;
    localparam int TAIL_RANDOM = 2;

    class deframe_scoreboard;
        logic [31:0] magic_cfg;
        logic [15:0] min_cfg;
        logic [15:0] max_cfg;
        bit          in_body;
        logic [63:0] hdr_bits;
        logic [15:0] count;
        logic [15:0] frame_len;
        logic [15:0] crc;
        logic [15:0] tail;
        result_t     waiting[$];
        int          errors;

        function new();
            errors = 0;
            magic_cfg = '0;
            min_cfg = MIN_LEN_LO;
            max_cfg = 16'hFFFF;
            frame_len = '0;
            restart();
        endfunction

        function void restart();
            in_body = 1'b0;
            hdr_bits = '0;
            count = '0;
            crc = CRC_INIT;
            tail = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_MAGIC:   magic_cfg = val;
                CFG_MIN_LEN: min_cfg = val[15:0];
                CFG_MAX_LEN: max_cfg = val[15:0];
                default: ;
            endcase
        endfunction

        // reflected MODBUS update, one byte
        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8)
            begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function int outstanding();
            return waiting.size();
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] magic_f;
            logic [31:0] len_f;
            logic [15:0] lo;
            result_t     r;
            r = '0;
            if (in_body)
            begin
                crc = crc_next(crc, b);
                tail = {tail[7:0], b};
                count = count + 16'd1;
                r.body_byte = b;
                r.body_length = frame_len;
                if (count >= frame_len)
                begin
                    r.frame_end = 1'b1;
                    r.status = (crc == 16'h0000 || tail == PASS_MARK) ? ST_GOOD : ST_BAD_CRC;
                    restart();
                end
                waiting.push_back(r);
                return;
            end
            // header: bytes past the two fields are dropped
            if (count < FIELD_BYTES)
                hdr_bits = {hdr_bits[55:0], b};
            count = count + 16'd1;
            if (count < HEADER_BYTES)
                return;
            magic_f = hdr_bits[63:32];
            len_f = hdr_bits[31:0];
            lo = (min_cfg < MIN_LEN_LO) ? MIN_LEN_LO : min_cfg;
            r.frame_end = 1'b1;
            if (magic_f != magic_cfg)
            begin
                r.status = ST_BAD_MAGIC;
                restart();
                waiting.push_back(r);
            end
            else if (len_f[31] || len_f < {16'h0000, lo} || len_f > {16'h0000, max_cfg})
            begin
                r.status = ST_BAD_LEN;
                restart();
                waiting.push_back(r);
            end
            else
            begin
                in_body = 1'b1;
                frame_len = len_f[15:0];
                count = '0;
                crc = CRC_INIT;
                tail = '0;
            end
        endfunction

        function void flag(string field, logic [15:0] exp_v, logic [15:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (waiting.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %0h",
                         $time, got);
                return;
            end
            exp_r = waiting.pop_front();
            if (got.body_byte !== exp_r.body_byte)
                flag("body_byte", 16'(exp_r.body_byte), 16'(got.body_byte));
            if (got.frame_end !== exp_r.frame_end)
                flag("frame_end", 16'(exp_r.frame_end), 16'(got.frame_end));
            if (got.status !== exp_r.status)
                flag("status", 16'(exp_r.status), 16'(got.status));
            if (got.body_length !== exp_r.body_length)
                flag("body_length", exp_r.body_length, got.body_length);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  body_byte;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] body_length;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    deframe_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int bytes_sent;
    int cycles;
    bit pressure_done;

    magic_length_crc_frame_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .body_byte   (body_byte),
        .frame_end   (frame_end),
        .status      (status),
        .body_length (body_length),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // receiver: random stall, or a long hold-off when requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(rx_byte);
            if (out_valid && !out_stall)
                sb.check_result({body_byte, frame_end, status, body_length});
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] magic, input logic [31:0] len);
        for (int i = 0; i < 4; i++)
            send_byte(8'(magic >> (24 - 8 * i)));
        for (int i = 0; i < 4; i++)
            send_byte(8'(len >> (24 - 8 * i)));
        repeat (HEADER_BYTES - FIELD_BYTES)
            send_byte(8'($urandom));
    endtask

    task automatic send_frame(input logic [31:0] magic, input int len, input int tail_mode);
        logic [15:0] c;
        logic [7:0]  b;
        c = CRC_INIT;
        send_header(magic, len);
        for (int i = 0; i < len - 2; i++)
        begin
            b = 8'($urandom);
            c = deframe_scoreboard::crc_next(c, b);
            send_byte(b);
        end
        case (tail_mode)
            TAIL_CRC:
            begin
                send_byte(c[7:0]);
                send_byte(c[15:8]);
            end
            TAIL_MARK:
            begin
                send_byte(PASS_MARK[7:0]);
                send_byte(PASS_MARK[15:8]);
            end
            default:
            begin
                send_byte(8'($urandom));
                send_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic send_bad_length(input logic [31:0] magic, input int lo, input int hi);
        logic [31:0] len;
        case ($urandom_range(0, 6))
            0: len = 32'h8000_0000 | $urandom;
            1: len = 32'd0;
            2: len = 32'd1;
            3: len = lo - 1;
            4: len = hi + 1;
            5: len = {1'b0, 15'($urandom_range(1, 32767)), 16'($urandom)};
            default: len = $urandom_range(2, 65535);
        endcase
        send_header(magic, len);
    endtask

    // stop offering, let every result come out, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // upper bits of the length writes are junk, the block must mask them
    task automatic apply_settings(input logic [31:0] magic, input logic [15:0] min_len,
                                  input logic [15:0] max_len);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_MIN_LEN, {16'($urandom), min_len});
        write_reg(CFG_MAX_LEN, {16'($urandom), max_len});
        write_reg(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(input int n_bytes, input bit with_pressure);
        int start;
        int lo;
        int hi;
        int span;
        int len;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            lo = (sb.min_cfg < MIN_LEN_LO) ? int'(MIN_LEN_LO) : int'(sb.min_cfg);
            hi = int'(sb.max_cfg);
            pick = $urandom_range(0, 99);
            if (with_pressure && !pressure_done && bytes_sent - start > 100)
            begin
                // receiver holds off while a long frame is offered
                pressure_done = 1'b1;
                hold_request = HOLD_CYCLES;
                send_frame(sb.magic_cfg, 64, TAIL_CRC);
                wait_drained();
            end
            else if (pick < 70 && lo <= hi)
            begin
                span = ($urandom_range(0, 19) == 0) ? 300 : 24;
                len = lo + $urandom_range(0, (hi - lo < span) ? hi - lo : span);
                send_frame(sb.magic_cfg, len, $urandom_range(TAIL_CRC, TAIL_RANDOM));
            end
            else if (pick < 82)
                send_bad_length(sb.magic_cfg, lo, hi);
            else if (pick < 92)
                send_header(sb.magic_cfg ^ (32'h1 << $urandom_range(0, 31)), $urandom);
            else
                repeat (HEADER_BYTES)
                    send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        hold_request = 0;
        bytes_sent = 0;
        pressure_done = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 56;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MAGIC;
        cfg_data  <= 32'h0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: both errors at once, negative length, shortest frame
        send_header(32'h0000_0001, 32'h8000_0000);
        send_header(32'h0000_0000, 32'hFFFF_FFFF);
        send_frame(32'h0000_0000, 2, TAIL_MARK);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: apply_settings($urandom, 16'd2, 16'hFFFF);
                1: apply_settings(32'hFFFF_FFFF, 16'd0, 16'd40);
                2: apply_settings($urandom, 16'd10, 16'd10);
                3: apply_settings(32'h0000_0000, 16'hFFFF, 16'd2);
                4: apply_settings($urandom, 16'd2, 16'd2);
                default: apply_settings($urandom, 16'd3, 16'd300);
            endcase
            run_traffic(PHASE_BYTES, p == 0);
            wait_drained();
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
